/* design/pwl_pkg.sv */
// Shared widths, codes and types for the piecewise linear table interpolator.
`timescale 1ns / 1ps

package pwl_pkg;

  localparam int unsigned MAX_POINTS = 256;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned IDX_W      = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int unsigned MUL_W      = VALUE_W + 1;
  localparam int unsigned PROD_W     = 2 * MUL_W;
  localparam int unsigned MUL_CNT_W  = $clog2(MUL_W);
  localparam int unsigned DIV_CNT_W  = $clog2(FRAC_BITS);

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_INTERP = 2'd2,
    ACT_SCALE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_ORDER = 2'd3
  } status_e;

endpackage

/* design/pwl_div.sv */
// Bit-serial restoring divider that produces the segment fraction.
`timescale 1ns / 1ps

module pwl_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [pwl_pkg::TIME_W-1:0]        num_i,
  input  logic [pwl_pkg::TIME_W-1:0]        den_i,
  output logic                              done_o,
  output logic [pwl_pkg::FRAC_BITS-1:0]     quo_o
);

  logic                               busy_q;
  logic                               done_q;
  logic [pwl_pkg::DIV_CNT_W-1:0]      cnt_q;
  logic [pwl_pkg::TIME_W-1:0]         rem_q;
  logic [pwl_pkg::TIME_W-1:0]         den_q;
  logic [pwl_pkg::FRAC_BITS-1:0]      quo_q;
  logic [pwl_pkg::TIME_W:0]           shifted;
  logic                               fits;
  logic [pwl_pkg::TIME_W:0]           diff;

  // remainder stays below the divisor, so one quotient bit per cycle
  assign shifted = {rem_q, 1'b0};
  assign fits    = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == pwl_pkg::DIV_CNT_W'(pwl_pkg::FRAC_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? diff[pwl_pkg::TIME_W-1:0] : shifted[pwl_pkg::TIME_W-1:0];
      quo_q <= {quo_q[pwl_pkg::FRAC_BITS-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* design/pwl_mul.sv */
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module pwl_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [pwl_pkg::MUL_W-1:0]  a_i,
  input  logic signed [pwl_pkg::MUL_W-1:0]  b_i,
  output logic                              done_o,
  output logic signed [pwl_pkg::PROD_W-1:0] prod_o
);

  logic                               busy_q;
  logic                               done_q;
  logic [pwl_pkg::MUL_CNT_W-1:0]      cnt_q;
  logic signed [pwl_pkg::MUL_W:0]     mcand_q;
  logic signed [pwl_pkg::MUL_W:0]     hi_q;
  logic [pwl_pkg::MUL_W-1:0]          lo_q;
  logic                               last;
  logic signed [pwl_pkg::MUL_W:0]     addend;
  logic signed [pwl_pkg::MUL_W:0]     sum;

  assign last = cnt_q == pwl_pkg::MUL_CNT_W'(pwl_pkg::MUL_W - 1);

  // sign bit of the multiplier carries negative weight: subtract there
  always_comb begin
    if (!lo_q[0]) begin
      addend = '0;
    end else if (last) begin
      addend = -mcand_q;
    end else begin
      addend = mcand_q;
    end
    sum = hi_q + addend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= {a_i[pwl_pkg::MUL_W-1], a_i};
      hi_q    <= '0;
      lo_q    <= b_i;
    end else if (busy_q) begin
      hi_q <= {sum[pwl_pkg::MUL_W], sum[pwl_pkg::MUL_W:1]};
      lo_q <= {sum[0], lo_q[pwl_pkg::MUL_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q[pwl_pkg::MUL_W-1:0], lo_q};

endmodule

/* design/piecewise_linear_table_interpolator.sv */
// Top level: breakpoint table, segment search and interpolation sequencer.
`timescale 1ns / 1ps

// Holds up to MAX_POINTS (time, value) breakpoints in a table with one write and
// one registered read port, and answers one transaction at a time. Clear and
// append go straight to the done state. A query reads the first and last points
// (a wait and an evaluate state each), then runs a binary search, each step
// passing the search, wait and evaluate states, at most ceil(log2(N-1)) steps
// over N points, through the registered table read; the segment fraction comes
// from a bit-serial divider and the product from a bit-serial multiplier. A
// query at or beyond the table's ends skips the search, divider and multiplier;
// a scaled query adds another multiplier pass. A finished result sits in the
// output register, so the next transaction is taken while it waits.
module piecewise_linear_table_interpolator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          action_i,
  input  logic [pwl_pkg::TIME_W-1:0]          sample_time_i,
  input  logic signed [pwl_pkg::VALUE_W-1:0]  sample_value_i,
  input  logic signed [pwl_pkg::VALUE_W-1:0]  factor_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pwl_pkg::VALUE_W-1:0]  result_value_o,
  output logic [1:0]                          status_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_WAIT,
    S_EVAL,
    S_SEARCH,
    S_DIV,
    S_MUL_I,
    S_SCALE_CHK,
    S_MUL_S,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_LAST,
    PH_MID
  } phase_e;

  localparam int unsigned WORD_W = pwl_pkg::TIME_W + pwl_pkg::VALUE_W;
  localparam int unsigned FB     = pwl_pkg::FRAC_BITS;

  state_e                              state_q;
  phase_e                              phase_q;
  logic [pwl_pkg::CNT_W-1:0]           count_q;
  logic [pwl_pkg::TIME_W-1:0]          last_time_q;
  pwl_pkg::action_e                    action_q;
  logic [pwl_pkg::TIME_W-1:0]          time_q;
  logic signed [pwl_pkg::VALUE_W-1:0]  factor_q;
  logic [pwl_pkg::IDX_W-1:0]           addr_q;
  logic [pwl_pkg::IDX_W-1:0]           lo_q;
  logic [pwl_pkg::IDX_W-1:0]           hi_q;
  logic [pwl_pkg::TIME_W-1:0]          t_lo_q;
  logic [pwl_pkg::TIME_W-1:0]          t_hi_q;
  logic signed [pwl_pkg::VALUE_W-1:0]  v_lo_q;
  logic signed [pwl_pkg::VALUE_W-1:0]  v_hi_q;
  logic signed [pwl_pkg::VALUE_W-1:0]  res_q;
  pwl_pkg::status_e                    status_q;
  logic                                out_valid_q;
  logic signed [pwl_pkg::VALUE_W-1:0]  out_value_q;
  pwl_pkg::status_e                    out_status_q;
  logic                                div_start_q;
  logic                                mul_start_q;

  logic [WORD_W-1:0]                   point_mem [pwl_pkg::MAX_POINTS];
  logic [WORD_W-1:0]                   rdata_q;

  logic                                in_accept;
  pwl_pkg::action_e                    in_action;
  logic                                append_ok;
  logic [pwl_pkg::TIME_W-1:0]          rd_time;
  logic signed [pwl_pkg::VALUE_W-1:0]  rd_value;
  logic [pwl_pkg::IDX_W-1:0]           last_idx;
  logic [pwl_pkg::IDX_W-1:0]           span;
  logic                                div_done;
  logic [FB-1:0]                       div_quo;
  logic                                mul_done;
  logic signed [pwl_pkg::PROD_W-1:0]   mul_prod;
  logic signed [pwl_pkg::MUL_W-1:0]    mul_a;
  logic signed [pwl_pkg::MUL_W-1:0]    mul_b;
  logic [pwl_pkg::PROD_W-FB-pwl_pkg::VALUE_W:0] sat_top;
  logic signed [pwl_pkg::VALUE_W-1:0]  scaled;

  assign in_stall_o = state_q != S_IDLE;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_action  = pwl_pkg::action_e'(action_i);
  assign append_ok  = (count_q < pwl_pkg::CNT_W'(pwl_pkg::MAX_POINTS))
                   && !((count_q != '0) && (sample_time_i < last_time_q));

  assign rd_time  = rdata_q[WORD_W-1:pwl_pkg::VALUE_W];
  assign rd_value = rdata_q[pwl_pkg::VALUE_W-1:0];
  assign last_idx = pwl_pkg::IDX_W'(count_q - 1'b1);
  assign span     = hi_q - lo_q;

  // table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (in_accept && (in_action == pwl_pkg::ACT_APPEND) && append_ok) begin
      point_mem[count_q[pwl_pkg::IDX_W-1:0]] <= {sample_time_i, sample_value_i};
    end
    rdata_q <= point_mem[addr_q];
  end

  // multiplier serves the segment product and then the scaling
  always_comb begin
    if (state_q == S_MUL_S) begin
      mul_a = {res_q[pwl_pkg::VALUE_W-1], res_q};
      mul_b = {factor_q[pwl_pkg::VALUE_W-1], factor_q};
    end else begin
      mul_a = {v_hi_q[pwl_pkg::VALUE_W-1], v_hi_q} - {v_lo_q[pwl_pkg::VALUE_W-1], v_lo_q};
      mul_b = {{(pwl_pkg::MUL_W - FB){1'b0}}, div_quo};
    end
  end

  // saturate when the bits above the result are not all copies of its sign
  assign sat_top = mul_prod[pwl_pkg::PROD_W-1:FB+pwl_pkg::VALUE_W-1];
  always_comb begin
    if ((sat_top == '0) || (sat_top == '1)) begin
      scaled = mul_prod[FB+pwl_pkg::VALUE_W-1:FB];
    end else if (mul_prod[pwl_pkg::PROD_W-1]) begin
      scaled = {1'b1, {(pwl_pkg::VALUE_W-1){1'b0}}};
    end else begin
      scaled = {1'b0, {(pwl_pkg::VALUE_W-1){1'b1}}};
    end
  end

  pwl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (time_q - t_lo_q),
    .den_i   (t_hi_q - t_lo_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  pwl_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      phase_q      <= PH_FIRST;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      div_start_q  <= 1'b0;
      mul_start_q  <= 1'b0;
      action_q     <= pwl_pkg::ACT_CLEAR;
      status_q     <= pwl_pkg::ST_OK;
      out_status_q <= pwl_pkg::ST_OK;
    end else begin
      div_start_q <= 1'b0;
      mul_start_q <= 1'b0;
      if ((state_q == S_DONE) && (!out_valid_q || !out_stall_i)) begin
        out_valid_q  <= 1'b1;
        out_value_q  <= res_q;
        out_status_q <= status_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            action_q <= in_action;
            time_q   <= sample_time_i;
            factor_q <= factor_i;
            res_q    <= '0;
            status_q <= pwl_pkg::ST_OK;
            state_q  <= S_DONE;
            unique case (in_action)
              pwl_pkg::ACT_CLEAR: begin
                count_q <= '0;
              end
              pwl_pkg::ACT_APPEND: begin
                if (count_q >= pwl_pkg::CNT_W'(pwl_pkg::MAX_POINTS)) begin
                  status_q <= pwl_pkg::ST_FULL;
                end else if (!append_ok) begin
                  status_q <= pwl_pkg::ST_ORDER;
                end else begin
                  count_q     <= count_q + 1'b1;
                  last_time_q <= sample_time_i;
                end
              end
              pwl_pkg::ACT_INTERP, pwl_pkg::ACT_SCALE: begin
                if (count_q == '0) begin
                  status_q <= pwl_pkg::ST_EMPTY;
                end else begin
                  addr_q  <= '0;
                  phase_q <= PH_FIRST;
                  state_q <= S_WAIT;
                end
              end
              default: ;
            endcase
          end
        end
        S_WAIT: begin
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          unique case (phase_q)
            PH_FIRST: begin
              t_lo_q <= rd_time;
              v_lo_q <= rd_value;
              if (time_q <= rd_time) begin
                res_q   <= rd_value;
                state_q <= S_SCALE_CHK;
              end else begin
                addr_q  <= last_idx;
                phase_q <= PH_LAST;
                state_q <= S_WAIT;
              end
            end
            PH_LAST: begin
              t_hi_q <= rd_time;
              v_hi_q <= rd_value;
              if (time_q >= rd_time) begin
                res_q   <= rd_value;
                state_q <= S_SCALE_CHK;
              end else begin
                lo_q    <= '0;
                hi_q    <= last_idx;
                state_q <= S_SEARCH;
              end
            end
            PH_MID: begin
              if (rd_time <= time_q) begin
                lo_q   <= addr_q;
                t_lo_q <= rd_time;
                v_lo_q <= rd_value;
              end else begin
                hi_q   <= addr_q;
                t_hi_q <= rd_time;
                v_hi_q <= rd_value;
              end
              state_q <= S_SEARCH;
            end
            default: state_q <= S_SEARCH;
          endcase
        end
        S_SEARCH: begin
          if (span > pwl_pkg::IDX_W'(1)) begin
            addr_q  <= lo_q + (span >> 1);
            phase_q <= PH_MID;
            state_q <= S_WAIT;
          end else if (t_hi_q == t_lo_q) begin
            // zero-length segment: take its lower value
            res_q   <= v_lo_q;
            state_q <= S_SCALE_CHK;
          end else begin
            div_start_q <= 1'b1;
            state_q     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            mul_start_q <= 1'b1;
            state_q     <= S_MUL_I;
          end
        end
        S_MUL_I: begin
          if (mul_done) begin
            res_q   <= v_lo_q + mul_prod[FB+pwl_pkg::VALUE_W-1:FB];
            state_q <= S_SCALE_CHK;
          end
        end
        S_SCALE_CHK: begin
          if (action_q == pwl_pkg::ACT_SCALE) begin
            mul_start_q <= 1'b1;
            state_q     <= S_MUL_S;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_MUL_S: begin
          if (mul_done) begin
            res_q   <= scaled;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid_q || !out_stall_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign status_o       = out_status_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pwl_pkg::CNT_W'(pwl_pkg::MAX_POINTS))
    else $error("point count exceeds table depth");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != pwl_pkg::ST_OK) |-> result_value_o == '0)
    else $error("error status with nonzero result");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the divide step");

  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_MUL_I) || (state_q == S_MUL_S))
    else $error("multiplier finished outside a multiply step");

  a_search_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEARCH |-> lo_q < hi_q)
    else $error("search bounds crossed");
`endif

endmodule
